// ----- src/fcm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the file allocation table chain manager.
// No dependencies; imported by every module of the block.
package fcm_pkg;

  // Default table depth (one link entry per disk block)
  localparam int DEF_NUM_BLOCKS = 1024;

  // Link entry encodings
  localparam logic [15:0] LINK_FREE = 16'hFFFF;
  localparam logic [15:0] LINK_END  = 16'hFFFE;

  // Request codes
  typedef enum logic [2:0] {
    ACT_FORMAT = 3'd0,
    ACT_ALLOC  = 3'd1,
    ACT_EXTEND = 3'd2,
    ACT_READ   = 3'd3,
    ACT_TAIL   = 3'd4,
    ACT_FREE   = 3'd5
  } act_t;

  // Result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_END    = 2'd2;
  localparam logic [1:0] STAT_UNUSED = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_LINK,
    S_WALK,
    S_RESP
  } state_t;

  // One result transfer
  typedef struct packed {
    logic [1:0] status;
    logic [9:0] result_block;
  } res_t;

  // Formatted layout: blocks 0, 2, 3 end chains, block 1 links to 2, rest free
  function automatic logic [15:0] fmt_link(input logic [15:0] idx);
    logic [15:0] v;
    v = LINK_FREE;
    if (idx == 16'd1) begin
      v = 16'd2;
    end else if (idx == 16'd0 || idx == 16'd2 || idx == 16'd3) begin
      v = LINK_END;
    end
    return v;
  endfunction

endpackage

// ----- src/fcm_link_ram.sv -----
`timescale 1ns / 1ps
// Link table storage: one write port, one read port, registered read data.
// Depends on fcm_pkg.
module fcm_link_ram
  import fcm_pkg::*;
#(
  parameter int DEPTH = DEF_NUM_BLOCKS,
  parameter int AW    = $clog2(DEF_NUM_BLOCKS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata_r
);

  logic [15:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, write-first on an address collision
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- src/fcm_out_stage.sv -----
`timescale 1ns / 1ps
// Output register for result transfers; frees the sequencer once a result is held.
// Depends on fcm_pkg.
module fcm_out_stage
  import fcm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  res_valid,
  input  res_t  res,
  output logic  res_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  logic valid_r;
  res_t data_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

endmodule

// ----- src/fcm_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the link table: clear sweep, free-entry scan and chain walks,
// one table visit per cycle through the shared read port. Depends on fcm_pkg.
module fcm_ctrl
  import fcm_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int IDX_W      = $clog2(DEF_NUM_BLOCKS)
) (
  input  logic             clk,
  input  logic             rst_n,
  // request
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [2:0]       req_action,
  input  logic [9:0]       req_block,
  // table port
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output logic [15:0]      mem_wdata,
  output logic [IDX_W-1:0] mem_raddr,
  input  logic [15:0]      mem_rdata,
  // result
  output logic             res_valid,
  output res_t             res,
  input  logic             res_ready
);

  localparam int          CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [15:0] NB16  = 16'(NUM_BLOCKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

  state_t           state_r, state_nxt;
  act_t             act_r, act_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] blk_r, blk_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             first_r, first_nxt;
  logic             fmt_r, fmt_nxt;
  res_t             res_r, res_nxt;

  act_t             in_act;
  logic [IDX_W-1:0] in_idx;
  logic             in_range;
  logic             rd_free;
  logic             rd_link;
  logic             idx_last;
  logic             walk_cap;
  logic             walk_stop;

  assign in_act    = act_t'(req_action);
  assign in_idx    = IDX_W'(req_block);
  assign in_range  = (32'(req_block) < NUM_BLOCKS);
  assign rd_free   = (mem_rdata == LINK_FREE);
  assign rd_link   = (mem_rdata < NB16);
  assign idx_last  = (idx_r == LAST_IDX);
  assign walk_cap  = (act_r == ACT_TAIL) && (cnt_r == CNT_W'(NUM_BLOCKS));
  assign walk_stop = rd_free || !rd_link || walk_cap;

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (idx_last) state_nxt = fmt_r ? S_RESP : S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          unique case (in_act)
            ACT_FORMAT: state_nxt = S_CLEAR;
            ACT_ALLOC:  state_nxt = S_SCAN;
            ACT_EXTEND,
            ACT_READ:   state_nxt = in_range ? S_FIRST : S_RESP;
            ACT_TAIL,
            ACT_FREE:   state_nxt = in_range ? S_WALK : S_RESP;
            default:    state_nxt = S_RESP;
          endcase
        end
      end
      S_FIRST: begin
        if (!rd_free && !rd_link && act_r == ACT_EXTEND) state_nxt = S_SCAN;
        else state_nxt = S_RESP;
      end
      S_SCAN: begin
        if (rd_free) state_nxt = (act_r == ACT_EXTEND) ? S_LINK : S_RESP;
        else if (idx_last) state_nxt = S_RESP;
      end
      S_LINK: state_nxt = S_RESP;
      S_WALK: begin
        if (walk_stop) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and table port control
  always_comb begin
    act_nxt   = act_r;
    idx_nxt   = idx_r;
    blk_nxt   = blk_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    fmt_nxt   = fmt_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = LINK_FREE;
    mem_raddr = idx_r;
    unique case (state_r)
      // sweep the formatted layout, one entry a cycle
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = fmt_link(16'(idx_r));
        idx_nxt   = idx_last ? '0 : idx_r + 1'b1;
        res_nxt   = '0;
      end
      // take a request, start the first table read
      S_IDLE: begin
        mem_raddr = (in_act == ACT_ALLOC) ? '0 : in_idx;
        if (req_valid) begin
          act_nxt   = in_act;
          blk_nxt   = in_idx;
          cur_nxt   = in_idx;
          prev_nxt  = in_idx;
          cnt_nxt   = '0;
          first_nxt = 1'b1;
          idx_nxt   = '0;
          fmt_nxt   = (in_act == ACT_FORMAT);
          res_nxt   = '0;
          if (!in_range && (in_act == ACT_EXTEND || in_act == ACT_READ ||
                            in_act == ACT_TAIL || in_act == ACT_FREE)) begin
            res_nxt.status = STAT_UNUSED;
          end
        end
      end
      // entry of the given block for read next and extend
      S_FIRST: begin
        mem_raddr = '0;
        idx_nxt   = '0;
        if (rd_free) begin
          res_nxt.status = STAT_UNUSED;
        end else if (rd_link) begin
          res_nxt.result_block = 10'(IDX_W'(mem_rdata));
        end else if (act_r == ACT_READ) begin
          res_nxt.status = STAT_END;
        end
      end
      // first-free scan; read of the next entry overlaps the check
      S_SCAN: begin
        mem_raddr = idx_last ? idx_r : idx_r + 1'b1;
        if (rd_free) begin
          mem_we               = 1'b1;
          mem_waddr            = idx_r;
          mem_wdata            = LINK_END;
          cur_nxt              = idx_r;
          res_nxt.result_block = 10'(idx_r);
        end else if (idx_last) begin
          res_nxt.status = STAT_FULL;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      // hook the new block after the given tail
      S_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = blk_r;
        mem_wdata = 16'(cur_r);
      end
      // chain walk: data is the link of cur_r, whose use is checked here
      S_WALK: begin
        mem_raddr = IDX_W'(mem_rdata);
        if (rd_free) begin
          if (first_r) res_nxt.status = STAT_UNUSED;
          else if (act_r == ACT_TAIL) res_nxt.result_block = 10'(prev_r);
        end else begin
          if (act_r == ACT_FREE) begin
            mem_we    = 1'b1;
            mem_waddr = cur_r;
            mem_wdata = LINK_FREE;
          end
          if (walk_stop) begin
            if (act_r == ACT_TAIL) res_nxt.result_block = 10'(cur_r);
          end else begin
            cur_nxt   = IDX_W'(mem_rdata);
            prev_nxt  = cur_r;
            cnt_nxt   = cnt_r + 1'b1;
            first_nxt = 1'b0;
          end
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
      fmt_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      fmt_r   <= fmt_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    blk_r   <= blk_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    cnt_r   <= cnt_nxt;
    first_r <= first_nxt;
    res_r   <= res_nxt;
  end

endmodule

// ----- src/fat_chain_manager_core.sv -----
`timescale 1ns / 1ps
// File allocation table chain manager. Scans, sweeps and chain walks are paced by the
// one-entry-a-cycle table port. One request at a time; in_tready rises with out_tvalid.
// Reset (synchronous, rst_n low) starts a sweep that writes the formatted layout;
// in_tready stays low until it ends.
// Depends on fcm_pkg, fcm_ctrl, fcm_link_ram, fcm_out_stage.
module fat_chain_manager_core
  import fcm_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] action, [12:3] block, [15:13] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [9:0] result_block, [11:10] status, [15:12] zero
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [15:0]      mem_rdata;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  res_t             out_res;

  // Sequencer
  fcm_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_action (in_tdata[2:0]),
    .req_block  (in_tdata[12:3]),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // Link table
  fcm_link_ram #(
    .DEPTH (NUM_BLOCKS),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  // Result register
  fcm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'd0, out_res.status, out_res.result_block};

endmodule

// ----- src/fcm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the chain manager, bound to the top level.
// Depends on fcm_pkg and fat_chain_manager_core.
module fcm_checker
  import fcm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The clearing sweep follows reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("request taken during the clearing sweep");

  // Only one request in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in work");

  // Any non-ok status names no block
  a_status_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11:10] != STAT_OK) |-> out_tdata[9:0] == 10'd0)
    else $error("block reported with an error status");

endmodule

bind fat_chain_manager_core fcm_checker u_fcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for fat_chain_manager_core: a request driver and a result
// monitor around the block, checked against an in-bench model of the link table.
// Depends on fcm_pkg and fat_chain_manager_core.
module tb;
  import fcm_pkg::*;

  localparam int NUM_BLOCKS  = DEF_NUM_BLOCKS;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int DRAIN_WAIT  = NUM_BLOCKS + 64;

  // Action codes the block ignores
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  typedef struct packed {
    logic [9:0] blk;
    logic [2:0] act;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;  // [2:0] action, [12:3] block, [15:13] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [9:0] result_block, [11:10] status, [15:12] zero

  fat_chain_manager_core #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Model of the link table and expected results
  logic [15:0] fat_links [0:NUM_BLOCKS-1];
  request_t    pending_requests [$];
  res_t        expected_results [$];

  request_t cur_req = '0;
  int       gap_left = 0;
  int       sent_count = 0;
  logic     idle_ok = 1'b1;
  int       hold_left = 0;
  logic     pressure_done = 1'b0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       cycle_count = 0;
  int       gen_live = 4;

  function automatic void format_links();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      fat_links[i] = LINK_FREE;
    end
    fat_links[0] = LINK_END;
    fat_links[1] = 16'd2;
    fat_links[2] = LINK_END;
    fat_links[3] = LINK_END;
  endfunction

  function automatic logic names_block(input int v);
    return v < NUM_BLOCKS;
  endfunction

  function automatic logic block_live(input int b);
    return b < NUM_BLOCKS && fat_links[b] != LINK_FREE;
  endfunction

  // Lowest free block, marked end of chain; NUM_BLOCKS when the table is full
  function automatic int claim_free_block();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (fat_links[i] == LINK_FREE) begin
        fat_links[i] = LINK_END;
        return i;
      end
    end
    return NUM_BLOCKS;
  endfunction

  function automatic res_t predict_request(input logic [2:0] act, input logic [9:0] blk);
    res_t r;
    int   f;
    int   cur;
    int   v;
    logic stop;
    r.result_block = '0;
    r.status = STAT_OK;
    cur = blk;
    stop = 1'b0;
    case (act)
      ACT_FORMAT: format_links();
      ACT_ALLOC: begin
        f = claim_free_block();
        if (f >= NUM_BLOCKS) r.status = STAT_FULL;
        else r.result_block = f[9:0];
      end
      ACT_EXTEND: begin
        if (!block_live(blk)) begin
          r.status = STAT_UNUSED;
        end else if (names_block(fat_links[blk])) begin
          // already has a successor: report it, allocate nothing
          r.result_block = fat_links[blk][9:0];
        end else begin
          f = claim_free_block();
          if (f >= NUM_BLOCKS) begin
            r.status = STAT_FULL;
          end else begin
            fat_links[blk] = f[15:0];
            r.result_block = f[9:0];
          end
        end
      end
      ACT_READ: begin
        if (!block_live(blk)) r.status = STAT_UNUSED;
        else if (names_block(fat_links[blk])) r.result_block = fat_links[blk][9:0];
        else r.status = STAT_END;
      end
      ACT_TAIL: begin
        if (!block_live(blk)) begin
          r.status = STAT_UNUSED;
        end else begin
          // stop at a chain end or a link into a free block
          for (int n = 0; n < NUM_BLOCKS && !stop; n++) begin
            v = fat_links[cur];
            if (!names_block(v) || !block_live(v)) stop = 1'b1;
            else cur = v;
          end
          r.result_block = cur[9:0];
        end
      end
      ACT_FREE: begin
        if (!block_live(blk)) begin
          r.status = STAT_UNUSED;
        end else begin
          for (int n = 0; n < NUM_BLOCKS && !stop; n++) begin
            v = fat_links[cur];
            fat_links[cur] = LINK_FREE;
            if (!names_block(v) || !block_live(v)) stop = 1'b1;
            else cur = v;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void push_req(input logic [2:0] act, input int blk);
    request_t q;
    q.act = act;
    q.blk = blk[9:0];
    pending_requests.push_back(q);
    if (act == ACT_FORMAT) gen_live = 4;
    else if ((act == ACT_ALLOC || act == ACT_EXTEND) && gen_live < NUM_BLOCKS - 1)
      gen_live = gen_live + 1;
  endfunction

  // Random requests, blocks mostly among those likely in use
  function automatic void push_random(input int count);
    int r;
    int b;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) b = $urandom_range(0, NUM_BLOCKS - 1);
      else b = $urandom_range(0, gen_live + 4);
      if (r < 3) push_req(ACT_FORMAT, b);
      else if (r < 28) push_req(ACT_ALLOC, b);
      else if (r < 53) push_req(ACT_EXTEND, b);
      else if (r < 68) push_req(ACT_READ, b);
      else if (r < 83) push_req(ACT_TAIL, b);
      else if (r < 95) push_req(ACT_FREE, b);
      else push_req(($urandom_range(0, 1) != 0) ? ACT_RSVD6 : ACT_RSVD7, b);
    end
  endfunction

  // Stimulus and end of run
  initial begin
    format_links();

    // directed: formatted layout, chain edits, dangling link, ignored codes
    push_req(ACT_READ, 1);
    push_req(ACT_READ, 0);
    push_req(ACT_READ, 4);
    push_req(ACT_READ, 1023);
    push_req(ACT_TAIL, 1);
    push_req(ACT_ALLOC, 0);
    push_req(ACT_EXTEND, 4);
    push_req(ACT_EXTEND, 1);
    push_req(ACT_EXTEND, 2);
    push_req(ACT_TAIL, 1);
    push_req(ACT_FREE, 2);
    push_req(ACT_TAIL, 1);
    push_req(ACT_READ, 1);
    push_req(ACT_EXTEND, 1);
    push_req(ACT_ALLOC, 0);
    push_req(ACT_RSVD6, 1023);
    push_req(ACT_RSVD7, 0);
    push_req(ACT_FREE, 1023);
    push_req(ACT_TAIL, 900);
    push_req(ACT_EXTEND, 1000);
    push_req(ACT_FREE, 1);
    push_req(ACT_ALLOC, 1023);
    push_req(ACT_FORMAT, 1023);
    push_req(ACT_READ, 1);

    push_random(300);
    push_random(256);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Request driver
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_request(cur_req.act, cur_req.blk));
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered transfer
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        gap_left <= $urandom_range(0, 11);
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        nxt = pending_requests.pop_front();
        cur_req <= nxt;
        in_tdata <= {3'b000, nxt.blk, nxt.act};
        in_tvalid <= 1'b1;
        sent_count <= sent_count + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
      // idle in stretches, none near the end
      idle_ok <= (sent_count % 160) < 120 && pending_requests.size() > 60;
    end
  end

  // Result monitor
  always @(posedge clk) begin : check_results
    res_t want;
    logic bad;
    bad = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: got %h", $time, out_tdata);
          bad = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[9:0] !== want.result_block) begin
            $display("%0t: result_block expected %0d got %0d", $time,
                     want.result_block, out_tdata[9:0]);
            bad = 1'b1;
          end
          if (out_tdata[11:10] !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time,
                     want.status, out_tdata[11:10]);
            bad = 1'b1;
          end
        end
        if (bad) mismatches <= mismatches + 1;
      end
      // long hold-off once so the block backs up into its input
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!pressure_done && results_seen >= 40) begin
        pressure_done <= 1'b1;
        hold_left <= 300;
        out_tready <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        hold_left <= $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
